[rtl/core/spf_pkg.sv]
// Shared types and constants for the sector packet framer.
// No dependencies; imported by every module of the framer.
`timescale 1ns / 1ps
`default_nettype none

package spf_pkg;

    localparam int SECTOR_BYTES_C = 512;
    localparam int CNT_W          = 10;
    localparam logic [CNT_W-1:0] SECTOR_BYTES = CNT_W'(SECTOR_BYTES_C);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [7:0]  HDR_MARK  = 8'h00;
    localparam logic [7:0]  DATA_MARK = 8'h01;
    localparam logic [7:0]  END_MARK  = 8'hFF;

    typedef enum logic [1:0] {
        CMD_HEADER  = 2'd0,
        CMD_BEGIN   = 2'd1,
        CMD_CONTENT = 2'd2,
        CMD_END     = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] status;
        logic [9:0] cylinder;
        logic [7:0] head;
        logic [5:0] sector;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_out_item;

    // One unit of work for the byte sequencer.
    typedef struct packed {
        t_cmd       cmd;
        logic       close_pkt;   // content byte that completes the packet
        logic [7:0] status;
        logic [9:0] cylinder;
        logic [7:0] head;
        logic [5:0] sector;
        logic [7:0] data_byte;
    } t_job;

endpackage

`default_nettype wire

[rtl/core/sector_packet_framer_crc16_unit.sv]
// Top level of the sector packet framer with CRC-16/XMODEM.
// Depends on spf_pkg, spf_front, spf_queue and spf_back.
`timescale 1ns / 1ps
`default_nettype none

// Frames disk-image commands into a serial byte stream. Each accepted input
// beat carries a command: header (emits 00, status, cylinder lo/hi, head,
// sector, CRC lo/hi), begin data packet (emits 01 and the same five address
// bytes and restarts the CRC), content byte (passed through and folded into
// the CRC; after SECTOR_BYTES of them the CRC follows, low byte first) and
// end (emits FF). Content bytes outside an open packet are swallowed with no
// output. The out "last" flag marks the final byte caused by one input beat.
// Timing: the front end accepts one beat per cycle while the four-entry job
// queue has room. The back-end byte sequencer issues one output byte per
// cycle while the output is not stalled: a content beat yields one byte
// (three when it closes the packet), a begin beat six, a header beat eight
// and an end beat one; that sequencer sets the sustained rate. When idle,
// an accepted beat is queued, then its first byte is registered for output.
// The CRC is folded one byte per cycle in the sequencer as bytes are issued.
module sector_packet_framer_crc16_unit
    import spf_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_item,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_item     o_out_item
);

    logic q_full, q_push, q_pop, q_valid;
    t_job push_job, head_job;

    // Classifies commands and tracks the open packet and its byte count.
    spf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_full     (q_full),
        .o_push     (q_push),
        .o_job      (push_job)
    );

    // Decouples front and back so each side stalls on its own.
    spf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    // Expands each job into its bytes and keeps the running CRC.
    spf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (head_job),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

[rtl/core/spf_front.sv]
// Front end: accepts commands, tracks packet state, emits jobs.
// Depends on spf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spf_front
    import spf_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_item,
    input  wire logic     i_full,
    output logic          o_push,
    output t_job          o_job
);

    logic             r_in_packet, n_in_packet;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] cnt_inc;
    logic             accept;
    t_cmd             cmd;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && !i_full;
    assign cmd        = t_cmd'(i_in_item.command);
    assign cnt_inc    = r_count + CNT_W'(1);

    always_comb begin
        n_in_packet     = r_in_packet;
        n_count         = r_count;
        o_push          = 1'b0;
        o_job.cmd       = cmd;
        o_job.close_pkt = 1'b0;
        o_job.status    = i_in_item.status;
        o_job.cylinder  = i_in_item.cylinder;
        o_job.head      = i_in_item.head;
        o_job.sector    = i_in_item.sector;
        o_job.data_byte = i_in_item.data_byte;
        if (accept) begin
            case (cmd)
                CMD_HEADER: begin
                    o_push      = 1'b1;
                    n_in_packet = 1'b0;
                    n_count     = '0;
                end
                CMD_BEGIN: begin
                    o_push      = 1'b1;
                    n_in_packet = 1'b1;
                    n_count     = '0;
                end
                CMD_CONTENT: begin
                    // outside a packet the byte is dropped
                    if (r_in_packet) begin
                        o_push = 1'b1;
                        if (cnt_inc >= SECTOR_BYTES) begin
                            o_job.close_pkt = 1'b1;
                            n_in_packet     = 1'b0;
                            n_count         = '0;
                        end else begin
                            n_count = cnt_inc;
                        end
                    end
                end
                default: begin
                    o_push      = 1'b1;
                    n_in_packet = 1'b0;
                    n_count     = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_packet <= 1'b0;
            r_count     <= '0;
        end else begin
            r_in_packet <= n_in_packet;
            r_count     <= n_count;
        end
    end

endmodule

`default_nettype wire

[rtl/core/spf_queue.sv]
// Small job queue between front end and byte sequencer.
// Depends on spf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spf_queue
    import spf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_job      o_job
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/spf_back.sv]
// Back end: byte sequencer with running CRC and output register.
// Depends on spf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spf_back
    import spf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_job_valid,
    input  wire t_job i_job,
    output logic      o_pop,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out_item o_out_item
);

    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    logic [2:0]  r_idx;
    logic [15:0] r_crc;
    logic        r_out_valid;
    t_out_item   r_out;

    logic        can_load, issue, is_last, fold_en, fold_zero;
    logic [2:0]  last_idx;
    logic [7:0]  sel_byte;
    logic [15:0] n_crc;

    assign can_load = !r_out_valid || i_out_ready;
    assign issue    = can_load && i_job_valid;
    assign is_last  = (r_idx == last_idx);
    assign o_pop    = issue && is_last;

    always_comb begin
        last_idx  = 3'd0;
        sel_byte  = END_MARK;
        fold_en   = 1'b0;
        fold_zero = 1'b0;
        case (i_job.cmd)
            CMD_HEADER, CMD_BEGIN: begin
                last_idx = (i_job.cmd == CMD_HEADER) ? 3'd7 : 3'd5;
                fold_en  = (r_idx < 3'd6);
                fold_zero = (r_idx == 3'd0);
                case (r_idx)
                    3'd0:    sel_byte = (i_job.cmd == CMD_HEADER) ? HDR_MARK : DATA_MARK;
                    3'd1:    sel_byte = i_job.status;
                    3'd2:    sel_byte = i_job.cylinder[7:0];
                    3'd3:    sel_byte = {6'b0, i_job.cylinder[9:8]};
                    3'd4:    sel_byte = i_job.head;
                    3'd5:    sel_byte = {2'b0, i_job.sector};
                    3'd6:    sel_byte = r_crc[7:0];
                    default: sel_byte = r_crc[15:8];
                endcase
            end
            CMD_CONTENT: begin
                last_idx = i_job.close_pkt ? 3'd2 : 3'd0;
                fold_en  = (r_idx == 3'd0);
                case (r_idx)
                    3'd0:    sel_byte = i_job.data_byte;
                    3'd1:    sel_byte = r_crc[7:0];
                    default: sel_byte = r_crc[15:8];
                endcase
            end
            default: begin
                sel_byte = END_MARK;
            end
        endcase
        n_crc = crc_fold(fold_zero ? 16'h0000 : r_crc, sel_byte);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_crc       <= '0;
            r_out_valid <= 1'b0;
        end else if (can_load) begin
            r_out_valid <= i_job_valid;
            if (i_job_valid) begin
                r_out.out_byte <= sel_byte;
                r_out.last     <= is_last;
                r_idx          <= is_last ? 3'd0 : r_idx + 3'd1;
                if (fold_en) begin
                    r_crc <= n_crc;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // A job in progress never leaves the queue head early.
    a_mid_job_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != 3'd0) |-> i_job_valid)
        else $error("sequencer mid-job with empty queue");

    // The step index never runs past the job's last byte.
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != 3'd0) |-> (r_idx <= last_idx))
        else $error("sequencer index beyond job length");

    // A non-final beat advances the step index by one.
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && issue && !is_last) |=> (r_idx == $past(r_idx) + 3'd1))
        else $error("sequencer index did not advance");

endmodule

`default_nettype wire

[tb/sv/tb_sector_packet_framer_crc16_unit.sv]
// Testbench for sector_packet_framer_crc16_unit: directed and random command beats, with a
// scoreboard class that predicts the framed byte stream and its CRC-16/XMODEM bytes.
// Depends on spf_pkg and the framer RTL only.
`timescale 1ns / 1ps

module tb_sector_packet_framer_crc16_unit;
    import spf_pkg::*;

    // Worst case is at most 131 input beats, each with up to 8 output bytes and
    // stall bursts on both sides; this limit sits several times above that.
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TOTAL_BEATS = 120;
    // After this many input beats both sides stop idling for the rest of the run.
    localparam int CALM_AFTER  = 90;

    // Tracks framer state (running CRC, content count, open packet) and holds the
    // bytes still owed by the DUT, oldest first.
    class stream_tracker;
        t_out_item   bytes_due[$];
        logic [15:0] crc_run;
        logic [9:0]  taken;
        bit          pkt_open;
        int          mismatches;

        function new();
            crc_run    = '0;
            taken      = '0;
            pkt_open   = 1'b0;
            mismatches = 0;
        endfunction

        // MSB-first CRC-16 update over one byte, no reflection.
        function logic [15:0] fold_crc(logic [15:0] crc, logic [7:0] b);
            logic [15:0] r;
            r = crc ^ {b, 8'h00};
            for (int i = 0; i < 8; i++) begin
                r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
            end
            return r;
        endfunction

        // Accepted input beat: queue the bytes it should produce. Returns their count.
        function int take_command(t_in_item it);
            logic [7:0]  seq[$];
            logic [15:0] hcrc;
            t_out_item   o;
            case (it.command)
                CMD_HEADER, CMD_BEGIN: begin
                    seq.push_back(it.command == CMD_HEADER ? HDR_MARK : DATA_MARK);
                    seq.push_back(it.status);
                    seq.push_back(it.cylinder[7:0]);
                    seq.push_back({6'b0, it.cylinder[9:8]});
                    seq.push_back(it.head);
                    seq.push_back({2'b0, it.sector});
                    hcrc = '0;
                    foreach (seq[i]) hcrc = fold_crc(hcrc, seq[i]);
                    // any open packet is dropped without its CRC
                    crc_run = hcrc;
                    taken   = '0;
                    if (it.command == CMD_HEADER) begin
                        seq.push_back(hcrc[7:0]);
                        seq.push_back(hcrc[15:8]);
                        pkt_open = 1'b0;
                    end else begin
                        pkt_open = 1'b1;
                    end
                end
                CMD_CONTENT: begin
                    // content outside a packet is swallowed
                    if (pkt_open) begin
                        crc_run = fold_crc(crc_run, it.data_byte);
                        seq.push_back(it.data_byte);
                        taken = taken + 10'd1;
                        if (taken >= SECTOR_BYTES) begin
                            seq.push_back(crc_run[7:0]);
                            seq.push_back(crc_run[15:8]);
                            pkt_open = 1'b0;
                            taken    = '0;
                        end
                    end
                end
                default: begin
                    seq.push_back(END_MARK);
                    pkt_open = 1'b0;
                    taken    = '0;
                end
            endcase
            foreach (seq[i]) begin
                o.out_byte = seq[i];
                o.last     = (i == seq.size() - 1);
                bytes_due.push_back(o);
            end
            return seq.size();
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            mismatches++;
        endtask

        // Accepted output beat: compare with the oldest byte owed.
        task match_byte(t_out_item got);
            t_out_item want;
            if (bytes_due.size() == 0) begin
                report($sformatf("byte %02h last %0b with nothing owed", got.out_byte, got.last));
                return;
            end
            want = bytes_due.pop_front();
            if (got.out_byte !== want.out_byte)
                report($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
            if (got.last !== want.last)
                report($sformatf("last %0b on byte %02h, want %0b", got.last, got.out_byte,
                                 want.last));
        endtask
    endclass

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;

    stream_tracker tracker = new();
    bit idle_on;
    int stall_left;
    int beats_sent;
    int cycles = 0;

    sector_packet_framer_crc16_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    // 12 ns clock
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Runaway guard.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Random fields for one command; unused fields stay random to show they are ignored.
    function automatic t_in_item make_cmd(t_cmd c);
        t_in_item it;
        it.command   = c;
        it.status    = 8'($urandom_range(0, 255));
        it.cylinder  = 10'($urandom_range(0, 1023));
        it.head      = 8'($urandom_range(0, 255));
        it.sector    = 6'($urandom_range(0, 63));
        it.data_byte = 8'($urandom_range(0, 255));
        return it;
    endfunction

    // One input beat. An optional idle burst comes first; valid is lowered only then,
    // so back-to-back beats keep valid high with a single assignment per step.
    task automatic push_command(input t_in_item it);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        // sample ready as seen by the edge that takes the beat
        do @(posedge clk); while (!in_ready);
        void'(tracker.take_command(it));
        beats_sent++;
    endtask

    task automatic push_fields(input t_cmd c, input logic [7:0] st, input logic [9:0] cyl,
                               input logic [7:0] hd, input logic [5:0] sec,
                               input logic [7:0] db);
        t_in_item it;
        it.command   = c;
        it.status    = st;
        it.cylinder  = cyl;
        it.head      = hd;
        it.sector    = sec;
        it.data_byte = db;
        push_command(it);
    endtask

    // Output side: checks every accepted byte, then picks ready for the next edge.
    // Stalls come in bursts of random length while idling is on.
    initial begin
        out_ready <= 1'b0;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) tracker.match_byte(out_item);
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 15) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int pick;
        int n;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_item  <= '0;
        idle_on  = 1'b1;
        beats_sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: header extremes, stray content and end outside a packet,
        // begin over an open packet, header over an open packet, end over an
        // open packet, and stray content after it.
        push_fields(CMD_HEADER,  8'h00, 10'd0,    8'h00, 6'd0,  8'h00);
        push_fields(CMD_HEADER,  8'hFF, 10'd1023, 8'hFF, 6'd63, 8'hFF);
        push_fields(CMD_CONTENT, 8'h00, 10'd0,    8'h00, 6'd0,  8'h5A);
        push_fields(CMD_END,     8'h00, 10'd0,    8'h00, 6'd0,  8'h00);
        push_fields(CMD_BEGIN,   8'hFF, 10'd1023, 8'hFF, 6'd63, 8'h00);
        push_fields(CMD_CONTENT, 8'hFF, 10'd1023, 8'hFF, 6'd63, 8'h00);
        push_fields(CMD_CONTENT, 8'h00, 10'd0,    8'h00, 6'd0,  8'hFF);
        push_fields(CMD_CONTENT, 8'h33, 10'd513,  8'h77, 6'd21, 8'hA5);
        push_fields(CMD_BEGIN,   8'h00, 10'd0,    8'h00, 6'd0,  8'hFF);
        push_fields(CMD_CONTENT, 8'h00, 10'd0,    8'h00, 6'd0,  8'h3C);
        push_fields(CMD_HEADER,  8'h5A, 10'd300,  8'h0F, 6'd17, 8'h00);
        push_fields(CMD_CONTENT, 8'h00, 10'd0,    8'h00, 6'd0,  8'hC3);
        push_fields(CMD_BEGIN,   8'h12, 10'h2AB,  8'h34, 6'd42, 8'h00);
        push_fields(CMD_CONTENT, 8'h00, 10'd0,    8'h00, 6'd0,  8'h81);
        push_fields(CMD_END,     8'hFF, 10'd1023, 8'hFF, 6'd63, 8'hFF);
        push_fields(CMD_CONTENT, 8'h00, 10'd0,    8'h00, 6'd0,  8'h42);

        // Random: mostly data packets of random length, usually ended by an end, a
        // header or the next begin, mixed with loose headers, end markers and stray commands.
        while (beats_sent < TOTAL_BEATS) begin
            idle_on = beats_sent < CALM_AFTER;
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                push_command(make_cmd(t_cmd'($urandom_range(0, 3))));
            end else if (pick == 1) begin
                push_command(make_cmd(CMD_HEADER));
            end else if (pick == 2) begin
                push_command(make_cmd(CMD_END));
            end else begin
                push_command(make_cmd(CMD_BEGIN));
                n = $urandom_range(0, 10);
                repeat (n) push_command(make_cmd(CMD_CONTENT));
                // packets are cut off by end, header, or the next begin
                case ($urandom_range(0, 2))
                    0: push_command(make_cmd(CMD_END));
                    1: push_command(make_cmd(CMD_HEADER));
                    default: ;
                endcase
            end
        end
        in_valid <= 1'b0;

        // Drain, then leave room for a stray late byte to show up.
        while (tracker.bytes_due.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.bytes_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
